[src/grouped_weighted_mean_defines.svh]
`ifndef GROUPED_WEIGHTED_MEAN_DEFINES_SVH
`define GROUPED_WEIGHTED_MEAN_DEFINES_SVH

// check that holds at every edge out of reset
`define GWM_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("gwm invariant violated");

// check in the cycle after a trigger
`define GWM_ASSERT_NEXT(lbl, trig, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error("gwm sequence violated");

`endif

[src/gwm_pkg.sv]
`default_nettype none
package gwm_pkg;

  localparam int ID_W    = 32;
  localparam int MEAN_W  = 32;
  localparam int WCNT_W  = 16;
  localparam int PROD_W  = MEAN_W + WCNT_W;
  localparam int SUM_W   = 54;
  localparam int CNT_W   = 22;
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [ID_W-1:0] MISSING_ID = 32'h8000_0000;

  // one queued record word
  typedef struct packed {
    logic signed [ID_W-1:0]   id;
    logic signed [PROD_W-1:0] prod;
    logic [WCNT_W-1:0]        cnt;
    logic                     absorb;
    logic                     fin;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

[src/gwm_front.sv]
`default_nettype none
module gwm_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [gwm_pkg::ID_W-1:0]      group_id,
  input  wire logic                                 id_present,
  input  wire logic signed [gwm_pkg::MEAN_W-1:0]    mean_value,
  input  wire logic [gwm_pkg::WCNT_W-1:0]           weight_count,
  input  wire logic                                 final_record,
  input  wire gwm_pkg::q_stat_t                     q_stat,
  output logic                                      push,
  output gwm_pkg::rec_t                             push_rec
);

  logic                              s_valid;
  logic signed [gwm_pkg::ID_W-1:0]   s_id;
  logic signed [gwm_pkg::MEAN_W-1:0] s_mean;
  logic [gwm_pkg::WCNT_W-1:0]        s_cnt;
  logic                              s_abs;
  logic                              s_fin;

  assign in_stall = s_valid && q_stat.full;
  assign push     = s_valid && !q_stat.full;

  always_comb begin
    push_rec.id     = s_id;
    push_rec.prod   = $signed({{(gwm_pkg::PROD_W-gwm_pkg::MEAN_W){s_mean[gwm_pkg::MEAN_W-1]}},
                               s_mean}) *
                      $signed({{(gwm_pkg::PROD_W-gwm_pkg::WCNT_W){1'b0}}, s_cnt});
    push_rec.cnt    = s_cnt;
    push_rec.absorb = s_abs;
    push_rec.fin    = s_fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s_valid <= 1'b1;
      s_id    <= group_id;
      s_mean  <= mean_value;
      s_cnt   <= weight_count;
      s_abs   <= id_present && (group_id != gwm_pkg::MISSING_ID);
      s_fin   <= final_record;
    end else if (push) begin
      s_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[src/gwm_fifo.sv]
`default_nettype none
module gwm_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire gwm_pkg::rec_t push_rec,
  input  wire logic          pop,
  output gwm_pkg::rec_t      head,
  output gwm_pkg::q_stat_t   q_stat
);

  localparam int PTR_W = $clog2(gwm_pkg::QUEUE_DEPTH);

  gwm_pkg::rec_t    mem [gwm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign head         = mem[rd_ptr];
  assign q_stat.full  = (fill == (PTR_W+1)'(gwm_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule
`default_nettype wire

[src/gwm_div.sv]
`default_nettype none
module gwm_div (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [gwm_pkg::SUM_W-1:0]   num,
  input  wire logic [gwm_pkg::CNT_W-1:0]          den,
  output logic                                    done,
  output logic signed [gwm_pkg::MEAN_W-1:0]       quot
);

  localparam int N     = gwm_pkg::SUM_W;
  localparam int D     = gwm_pkg::CNT_W;
  localparam int STEP_W = $clog2(N + 1);

  logic [N-1:0]      q;
  logic [D-1:0]      rem;
  logic [D-1:0]      dv;
  logic              neg;
  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [D:0]        trial;
  logic              fits;

  assign trial = {rem, q[N-1]};
  assign fits  = (trial >= {1'b0, dv});

  // truncated magnitude, then sign and clamp to 32 bits
  always_comb begin
    if (neg) begin
      if (q > N'(33'h1_0000_0000 >> 1)) quot = {1'b1, {(gwm_pkg::MEAN_W-1){1'b0}}};
      else quot = -$signed(q[gwm_pkg::MEAN_W-1:0]);
    end else begin
      if (q > N'(32'h7FFF_FFFF)) quot = {1'b0, {(gwm_pkg::MEAN_W-1){1'b1}}};
      else quot = $signed(q[gwm_pkg::MEAN_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        neg   <= num[N-1];
        q     <= num[N-1] ? N'(-num) : N'(num);
        rem   <= '0;
        dv    <= den;
        steps <= STEP_W'(N);
      end else if (busy) begin
        rem   <= fits ? D'(trial - {1'b0, dv}) : D'(trial);
        q     <= {q[N-2:0], fits};
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

[src/gwm_back.sv]
`default_nettype none
module gwm_back #(
  parameter int TABLE_DEPTH = gwm_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire gwm_pkg::q_stat_t                   q_stat,
  input  wire gwm_pkg::rec_t                      head,
  output logic                                    pop,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [gwm_pkg::ID_W-1:0]         out_id,
  output logic signed [gwm_pkg::MEAN_W-1:0]       combined_mean,
  output logic                                    zero_weight,
  output logic                                    groups_dropped,
  output logic                                    last_result
);

  localparam int USED_W = $clog2(TABLE_DEPTH + 1);
  localparam int SW = gwm_pkg::SUM_W;
  localparam int CW = gwm_pkg::CNT_W;

  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_APPLY, S_EMIT, S_DIV, S_OUT} state_t;

  state_t                              state;
  gwm_pkg::rec_t                       r;
  logic signed [gwm_pkg::ID_W-1:0]     key [TABLE_DEPTH];
  logic signed [SW-1:0]                sum [TABLE_DEPTH];
  logic [CW-1:0]                       cnt [TABLE_DEPTH];
  logic [USED_W-1:0]                   used;
  logic                                ovf;
  logic [TABLE_DEPTH-1:0]              eq_v;
  logic [TABLE_DEPTH-1:0]              gt_v;
  logic [TABLE_DEPTH-1:0]              eq_next;
  logic [TABLE_DEPTH-1:0]              gt_next;
  logic signed [SW-1:0]                sel_sum;
  logic [CW-1:0]                       sel_cnt;
  logic signed [SW-1:0]                sel_sum_next;
  logic [CW-1:0]                       sel_cnt_next;
  logic signed [SW:0]                  add_sum;
  logic signed [SW-1:0]                upd_sum;
  logic [CW:0]                         add_cnt;
  logic [CW-1:0]                       upd_cnt;
  logic                                zero_hold;
  logic                                div_start;
  logic                                div_done;
  logic signed [gwm_pkg::MEAN_W-1:0]   div_quot;
  logic                                out_free;

  assign out_free  = !out_valid || !out_stall;
  assign pop       = (state == S_IDLE) && !q_stat.empty;
  assign div_start = (state == S_EMIT) && (used != '0) && (cnt[0] != '0);

  // match and order flags, one per cell
  always_comb begin
    sel_sum_next = '0;
    sel_cnt_next = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      eq_next[k] = (USED_W'(k) < used) && (key[k] == r.id);
      gt_next[k] = (USED_W'(k) < used) && (key[k] > r.id);
      if (eq_next[k]) begin
        sel_sum_next = sel_sum_next | sum[k];
        sel_cnt_next = sel_cnt_next | cnt[k];
      end
    end
  end

  always_comb begin
    add_sum = {sel_sum[SW-1], sel_sum} + (SW+1)'(r.prod);
    if (add_sum[SW] != add_sum[SW-1])
      upd_sum = add_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    else
      upd_sum = add_sum[SW-1:0];
    add_cnt = {1'b0, sel_cnt} + (CW+1)'(r.cnt);
    upd_cnt = add_cnt[CW] ? {CW{1'b1}} : add_cnt[CW-1:0];
  end

  gwm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (sum[0]),
    .den   (cnt[0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            r     <= head;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          eq_v    <= eq_next;
          gt_v    <= gt_next;
          sel_sum <= sel_sum_next;
          sel_cnt <= sel_cnt_next;
          state   <= S_APPLY;
        end
        S_APPLY: begin
          if (r.absorb) begin
            if (eq_v != '0) begin
              for (int k = 0; k < TABLE_DEPTH; k++) begin
                if (eq_v[k]) begin
                  sum[k] <= upd_sum;
                  cnt[k] <= upd_cnt;
                end
              end
            end else if (used == USED_W'(TABLE_DEPTH)) begin
              ovf <= 1'b1;
            end else begin
              // shift the tail up one cell, new id lands at the front of it
              for (int k = 0; k < TABLE_DEPTH; k++) begin
                if (k > 0 && gt_v[(k > 0) ? k-1 : 0]) begin
                  key[k] <= key[(k > 0) ? k-1 : 0];
                  sum[k] <= sum[(k > 0) ? k-1 : 0];
                  cnt[k] <= cnt[(k > 0) ? k-1 : 0];
                end else if (gt_v[k] || USED_W'(k) == used) begin
                  key[k] <= r.id;
                  sum[k] <= SW'(r.prod);
                  cnt[k] <= CW'(r.cnt);
                end
              end
              used <= used + 1'b1;
            end
          end
          state <= r.fin ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (used == '0) begin
            ovf   <= 1'b0;
            state <= S_IDLE;
          end else if (cnt[0] == '0) begin
            zero_hold <= 1'b1;
            state     <= S_OUT;
          end else begin
            zero_hold <= 1'b0;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            out_id         <= key[0];
            combined_mean  <= zero_hold ? '0 : div_quot;
            zero_weight    <= zero_hold;
            groups_dropped <= ovf;
            last_result    <= (used == USED_W'(1));
            // head cell is done; pull the chain down
            for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
              key[k] <= key[k+1];
              sum[k] <= sum[k+1];
              cnt[k] <= cnt[k+1];
            end
            used <= used - 1'b1;
            if (used == USED_W'(1)) begin
              ovf   <= 1'b0;
              state <= S_IDLE;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/grouped_weighted_mean.sv]
// grouped_weighted_mean: group-by weighted mean over a record stream.
// Input channel (in_valid/in_stall) takes records of group id, Q16.16 partial
// mean and observation count. The front stage registers the record, forms
// mean*count and queues it (4 words deep); in_stall rises only when that
// queue is full. The back part pops one queued record only when idle: a
// compare pass over the sorted cell chain, then an update or insert.
// A record with final_record set starts emission after it is absorbed: one
// result per stored id, ascending, each quotient formed by the one-bit-per-cycle
// 54/22 divider shared by all entries with a nonzero count; a zero count
// skips it. last_result marks the final word; an empty table emits nothing.
// The output register holds its word while out_stall is high; the divider
// and chain wait, while input records keep queuing until the queue fills.
// Synchronous reset empties the table, the queue and the output register.
`default_nettype none
`include "grouped_weighted_mean_defines.svh"
module grouped_weighted_mean #(
  parameter int TABLE_DEPTH = gwm_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [gwm_pkg::ID_W-1:0]    group_id,
  input  wire logic                               id_present,
  input  wire logic signed [gwm_pkg::MEAN_W-1:0]  mean_value,
  input  wire logic [gwm_pkg::WCNT_W-1:0]         weight_count,
  input  wire logic                               final_record,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [gwm_pkg::ID_W-1:0]         out_id,
  output logic signed [gwm_pkg::MEAN_W-1:0]       combined_mean,
  output logic                                    zero_weight,
  output logic                                    groups_dropped,
  output logic                                    last_result
);

  gwm_pkg::q_stat_t q_stat;
  gwm_pkg::rec_t    push_rec;
  gwm_pkg::rec_t    head;
  logic             push;
  logic             pop;

  gwm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .group_id     (group_id),
    .id_present   (id_present),
    .mean_value   (mean_value),
    .weight_count (weight_count),
    .final_record (final_record),
    .q_stat       (q_stat),
    .push         (push),
    .push_rec     (push_rec)
  );

  gwm_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  gwm_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_stat         (q_stat),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_id         (out_id),
    .combined_mean  (combined_mean),
    .zero_weight    (zero_weight),
    .groups_dropped (groups_dropped),
    .last_result    (last_result)
  );

  `GWM_ASSERT_ALWAYS(a_no_push_full, !(push && q_stat.full))
  `GWM_ASSERT_ALWAYS(a_no_pop_empty, !(pop && q_stat.empty))
  `GWM_ASSERT_ALWAYS(a_stall_only_full, !in_stall || q_stat.full)
  `GWM_ASSERT_NEXT(a_push_fills, push && !pop, !q_stat.empty)

endmodule
`default_nettype wire
